>>> hw/rtl/dtq_pkg.sv
// ----------------------------------------------------------------------------
// dtq_pkg: shared types and codes of the deadline timer queue
// Request and response words, command codes, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package dtq_pkg;

	localparam int NUM_TIMERS_DEF = 16;

	localparam logic [2:0] CMD_TICK    = 3'd0;
	localparam logic [2:0] CMD_START   = 3'd1;
	localparam logic [2:0] CMD_STOP    = 3'd2;
	localparam logic [2:0] CMD_QUERY   = 3'd3;
	localparam logic [2:0] CMD_SERVICE = 3'd4;
	localparam logic [2:0] CMD_RESPOND = 3'd5;

	localparam logic [1:0] RESP_NONE = 2'd0;
	localparam logic [1:0] RESP_SAME = 2'd1;

	localparam logic [31:0] INACTIVE_ANSWER = 32'hFFFF_FFFF;
	localparam logic [31:0] REMAIN_MAX      = 32'hFFFF_FFFE;

	typedef struct packed {
		logic [2:0]  command;
		logic [3:0]  slot;
		logic [31:0] period;
		logic [1:0]  response;
	} req_word_t;

	typedef struct packed {
		logic        expired_found;
		logic [3:0]  expired_slot;
		logic [31:0] remaining_ms;
		logic [63:0] time_now;
		logic        command_error;
	} rsp_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_EVAL,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT,
		ST_DONE
	} ctrl_state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_TICK,
		OP_START,
		OP_STOP,
		OP_RD_SLOT,
		OP_RD_PEND,
		OP_QEVAL,
		OP_ARM_RESP,
		OP_RESP_CLEAR,
		OP_ERR,
		OP_SCAN_INIT,
		OP_SCAN_STEP,
		OP_SCAN_COMMIT
	} dp_op_t;

	typedef struct packed {
		logic   load;
		logic   push;
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] command;
		logic [1:0] response;
		logic       pend_valid;
		logic       scan_last;
		logic       out_free;
	} dp_status_t;

endpackage

>>> hw/rtl/dtq_ctrl.sv
// ----------------------------------------------------------------------------
// dtq_ctrl: command sequencer
// Decodes the held request word and steps the datapath through execute,
// read, slot scan and result hand-off.
// ----------------------------------------------------------------------------
module dtq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  dtq_pkg::dp_status_t status,
	output dtq_pkg::dp_cmd_t    cmd
);
	import dtq_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		cmd.load  = 1'b0;
		cmd.push  = 1'b0;
		cmd.op    = OP_NONE;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_DONE;
				case (status.command)
					CMD_TICK:  cmd.op = OP_TICK;
					CMD_START: cmd.op = OP_START;
					CMD_STOP:  cmd.op = OP_STOP;
					CMD_QUERY: begin
						cmd.op  = OP_RD_SLOT;
						state_d = ST_EVAL;
					end
					CMD_SERVICE: begin
						cmd.op  = OP_SCAN_INIT;
						state_d = ST_SCAN;
					end
					CMD_RESPOND: begin
						if (!status.pend_valid) begin
							cmd.op = OP_ERR;
						end else if (status.response == RESP_NONE) begin
							cmd.op = OP_RESP_CLEAR;
						end else begin
							cmd.op  = OP_RD_PEND;
							state_d = ST_EVAL;
						end
					end
					default: cmd.op = OP_NONE;
				endcase
			end
			ST_EVAL: begin
				cmd.op  = (status.command == CMD_QUERY) ? OP_QEVAL : OP_ARM_RESP;
				state_d = ST_DONE;
			end
			ST_SCAN: begin
				cmd.op = OP_SCAN_STEP;
				if (status.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				cmd.op  = OP_SCAN_COMMIT;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.push = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

>>> hw/rtl/dtq_datapath.sv
// ----------------------------------------------------------------------------
// dtq_datapath: timer store, tick counter and result register
// Slot memories with one registered read port, active flags, the earliest
// due search and the response word register.
// ----------------------------------------------------------------------------
module dtq_datapath #(
	parameter int NUM_TIMERS = dtq_pkg::NUM_TIMERS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dtq_pkg::dp_cmd_t    cmd,
	output dtq_pkg::dp_status_t status,
	input  dtq_pkg::req_word_t  req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output dtq_pkg::rsp_word_t  rsp
);
	import dtq_pkg::*;

	localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

	logic [63:0] dl_mem  [NUM_TIMERS];
	logic [31:0] per_mem [NUM_TIMERS];
	logic [31:0] ord_mem [NUM_TIMERS];

	req_word_t       item_q;
	logic [63:0]     now_q;
	logic [31:0]     seq_q;
	logic [NUM_TIMERS-1:0] active_q;
	logic            pend_valid_q;
	logic [IW-1:0]   pend_slot_q;
	logic [63:0]     pend_dl_q;

	logic [IW-1:0]   scan_addr_q;
	logic [IW-1:0]   rd_idx_s1;
	logic            rd_vld_s1;
	logic            have_q;
	logic [IW-1:0]   best_q;
	logic [63:0]     best_dl_q;
	logic [31:0]     best_ord_q;

	logic [63:0]     dl_rd_q;
	logic [31:0]     per_rd_q;
	logic [31:0]     ord_rd_q;

	logic            res_found_q;
	logic [3:0]      res_slot_q;
	logic [31:0]     res_remain_q;
	logic            res_err_q;

	rsp_word_t       out_q;
	logic            out_valid_q;

	logic [IW-1:0]   slot_idx;
	logic            in_range;
	logic [IW-1:0]   rd_addr;
	logic [IW-1:0]   wr_addr;
	logic            wr_en;
	logic [63:0]     wr_dl;
	logic [31:0]     wr_per;
	logic [31:0]     resp_per;
	logic [64:0]     diff;
	logic            due;
	logic            sat;
	logic            cand;
	logic            better;

	assign slot_idx = IW'(item_q.slot);
	assign in_range = 32'(item_q.slot) < 32'(NUM_TIMERS);
	assign resp_per = (item_q.response == RESP_SAME) ? per_rd_q : item_q.period;

	always_comb begin
		case (cmd.op)
			OP_RD_SLOT: rd_addr = slot_idx;
			OP_RD_PEND: rd_addr = pend_slot_q;
			default:    rd_addr = scan_addr_q;
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = slot_idx;
		wr_dl   = now_q + {32'd0, item_q.period};
		wr_per  = item_q.period;
		case (cmd.op)
			OP_START: begin
				wr_en = in_range;
			end
			OP_ARM_RESP: begin
				wr_en   = 1'b1;
				wr_addr = pend_slot_q;
				wr_dl   = pend_dl_q + {32'd0, resp_per};
				wr_per  = resp_per;
			end
			default: wr_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			dl_mem[wr_addr]  <= wr_dl;
			per_mem[wr_addr] <= wr_per;
			ord_mem[wr_addr] <= seq_q;
		end
		dl_rd_q  <= dl_mem[rd_addr];
		per_rd_q <= per_mem[rd_addr];
		ord_rd_q <= ord_mem[rd_addr];
	end

	assign diff = {1'b0, dl_rd_q} - {1'b0, now_q};
	assign due  = diff[64] || (diff[63:0] == 64'd0);
	assign sat  = (diff[63:32] != 32'd0) || (diff[31:0] == INACTIVE_ANSWER);

	assign cand   = rd_vld_s1 && active_q[rd_idx_s1] && (dl_rd_q <= now_q);
	assign better = !have_q || (dl_rd_q < best_dl_q) ||
		((dl_rd_q == best_dl_q) && (ord_rd_q > best_ord_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q        <= 64'd0;
			seq_q        <= 32'd0;
			active_q     <= '0;
			pend_valid_q <= 1'b0;
			pend_slot_q  <= '0;
			pend_dl_q    <= 64'd0;
			rd_vld_s1    <= 1'b0;
			have_q       <= 1'b0;
			scan_addr_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			rd_vld_s1 <= (cmd.op == OP_SCAN_STEP);
			if (cand && better) begin
				have_q <= 1'b1;
			end
			if (wr_en) begin
				active_q[wr_addr] <= 1'b1;
				seq_q             <= seq_q + 32'd1;
			end
			case (cmd.op)
				OP_TICK: now_q <= now_q + 64'd1;
				OP_STOP: begin
					if (in_range) begin
						active_q[slot_idx] <= 1'b0;
					end
				end
				OP_ARM_RESP:   pend_valid_q <= 1'b0;
				OP_RESP_CLEAR: pend_valid_q <= 1'b0;
				OP_SCAN_INIT: begin
					scan_addr_q <= '0;
					have_q      <= 1'b0;
				end
				OP_SCAN_STEP: scan_addr_q <= scan_addr_q + IW'(1);
				OP_SCAN_COMMIT: begin
					if (have_q) begin
						active_q[best_q] <= 1'b0;
						pend_valid_q     <= 1'b1;
						pend_slot_q      <= best_q;
						pend_dl_q        <= best_dl_q;
					end
				end
				default: ;
			endcase
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_addr_q;
		if (cand && better) begin
			best_q     <= rd_idx_s1;
			best_dl_q  <= dl_rd_q;
			best_ord_q <= ord_rd_q;
		end
		if (cmd.load) begin
			item_q       <= req;
			res_found_q  <= 1'b0;
			res_slot_q   <= 4'd0;
			res_remain_q <= 32'd0;
			res_err_q    <= 1'b0;
		end else begin
			case (cmd.op)
				OP_ERR: res_err_q <= 1'b1;
				OP_QEVAL: begin
					if (!in_range || !active_q[slot_idx]) begin
						res_remain_q <= INACTIVE_ANSWER;
					end else if (due) begin
						res_remain_q <= 32'd0;
					end else if (sat) begin
						res_remain_q <= REMAIN_MAX;
					end else begin
						res_remain_q <= diff[31:0];
					end
				end
				OP_SCAN_COMMIT: begin
					if (have_q) begin
						res_found_q <= 1'b1;
						res_slot_q  <= 4'(best_q);
					end
				end
				default: ;
			endcase
		end
		if (cmd.push) begin
			out_q.expired_found <= res_found_q;
			out_q.expired_slot  <= res_slot_q;
			out_q.remaining_ms  <= res_remain_q;
			out_q.time_now      <= now_q;
			out_q.command_error <= res_err_q;
		end
	end

	assign status.command    = item_q.command;
	assign status.response   = item_q.response;
	assign status.pend_valid = pend_valid_q;
	assign status.scan_last  = (scan_addr_q == IW'(NUM_TIMERS - 1));
	assign status.out_free   = !out_valid_q || rsp_ready;

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

>>> hw/rtl/deadline_timer_queue.sv
// ----------------------------------------------------------------------------
// deadline_timer_queue: software timer queue on a 64-bit tick
// Tick, start, stop, query, service and respond commands over NUM_TIMERS
// slots; every request word gives exactly one response word.
// ----------------------------------------------------------------------------
// Usage:
//   Request words enter on req (req_valid/req_ready); one response word per
//   request leaves on rsp (rsp_valid/rsp_ready), in request order.
//   One request is worked at a time. Tick, start, stop, unused codes and
//   respond without restart go through execute and done; query and respond
//   with restart add one registered memory read and an evaluate step;
//   service scans one slot per cycle, then drains and commits the result.
//   req_ready returns the cycle after the response word is registered.
//   The response register lets the next request be taken and worked while
//   an earlier word waits; if the receiver stalls, the finished result is
//   held until the register frees and no further request is taken.
//   Reset clears time, active flags, start sequence and pending expiry;
//   slot memories need no clearing pass.
// ----------------------------------------------------------------------------
module deadline_timer_queue #(
	parameter int NUM_TIMERS = dtq_pkg::NUM_TIMERS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  dtq_pkg::req_word_t req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output dtq_pkg::rsp_word_t rsp
);
	import dtq_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	dtq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.status    (status),
		.cmd       (cmd)
	);

	dtq_datapath #(
		.NUM_TIMERS (NUM_TIMERS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

>>> bench/deadline_timer_queue_test.sv
// ----------------------------------------------------------------------------
// deadline_timer_queue_test: self-checking bench for the deadline timer queue
// A clocked driver offers request words from a stimulus queue, and a shadow
// timer queue predicts each response word. A clocked monitor compares every
// response field with the oldest prediction. Both sides idle in random
// bursts, the receiver stalls for one long stretch, and the sender pauses
// once or twice until every prediction has been answered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module deadline_timer_queue_test;
	import dtq_pkg::*;

	localparam int NTIMERS = NUM_TIMERS_DEF;
	localparam int RANDOM_WORDS = 1600;
	localparam int CALM_TAIL = 150;
	localparam int LONG_HOLD = 400;
	localparam int HOLD_AT = 500;
	localparam int SETTLE = 40;
	localparam int LIMIT = 600000;

	localparam logic [1:0] RESP_NEW = 2'd2;
	localparam logic [1:0] RESP_ODD = 2'd3;
	localparam logic [2:0] CMD_SPARE6 = 3'd6;
	localparam logic [2:0] CMD_SPARE7 = 3'd7;

	typedef struct {
		req_word_t word;
		bit        drain_first;
	} stim_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	req_word_t req = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	rsp_word_t rsp;

	stim_t     cmd_q[$];
	rsp_word_t answer_q[$];
	int        errors = 0;
	int        sent = 0;
	int        gap_left = 0;
	int        stall_left = 0;
	int        hold_left = 0;
	bit        hold_done = 0;
	logic      long_hold = 1'b0;
	logic      calm = 1'b0;
	longint    cycles = 0;

	// shadow timer queue
	logic [63:0] tick_now = '0;
	bit          armed[NTIMERS];
	logic [63:0] due_at[NTIMERS];
	logic [31:0] slot_per[NTIMERS];
	logic [31:0] arm_order[NTIMERS];
	logic [31:0] arm_seq = '0;
	bit          exp_pending = 0;
	logic [3:0]  exp_slot = '0;
	logic [63:0] exp_due = '0;

	deadline_timer_queue dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void arm_timer(logic [3:0] s, logic [63:0] due);
		due_at[s] = due;
		armed[s] = 1;
		arm_order[s] = arm_seq;
		arm_seq = arm_seq + 32'd1;
	endfunction

	function automatic rsp_word_t queue_answer(req_word_t w);
		rsp_word_t   r;
		bit          have;
		int          best;
		logic [63:0] left;
		r = '0;
		have = 0;
		best = 0;
		case (w.command)
		CMD_TICK: tick_now = tick_now + 64'd1;
		CMD_START: begin
			if (w.slot < NTIMERS) begin
				slot_per[w.slot] = w.period;
				arm_timer(w.slot, tick_now + w.period);
			end
		end
		CMD_STOP: begin
			if (w.slot < NTIMERS)
				armed[w.slot] = 0;
		end
		CMD_QUERY: begin
			if (w.slot >= NTIMERS || !armed[w.slot]) begin
				r.remaining_ms = INACTIVE_ANSWER;
			end else if (tick_now >= due_at[w.slot]) begin
				r.remaining_ms = '0;
			end else begin
				left = due_at[w.slot] - tick_now;
				r.remaining_ms = (left > REMAIN_MAX) ? REMAIN_MAX : left[31:0];
			end
		end
		CMD_SERVICE: begin
			for (int i = 0; i < NTIMERS; i++) begin
				if (!armed[i] || due_at[i] > tick_now)
					continue;
				if (!have || due_at[i] < due_at[best] ||
						(due_at[i] == due_at[best] && arm_order[i] > arm_order[best])) begin
					best = i;
					have = 1;
				end
			end
			if (have) begin
				armed[best] = 0;
				exp_pending = 1;
				exp_slot = best[3:0];
				exp_due = due_at[best];
				r.expired_found = 1'b1;
				r.expired_slot = best[3:0];
			end
		end
		CMD_RESPOND: begin
			if (!exp_pending) begin
				r.command_error = 1'b1;
			end else begin
				exp_pending = 0;
				if (w.response != RESP_NONE) begin
					if (w.response != RESP_SAME)
						slot_per[exp_slot] = w.period;
					arm_timer(exp_slot, exp_due + slot_per[exp_slot]);
				end
			end
		end
		default: ;
		endcase
		r.time_now = tick_now;
		return r;
	endfunction

	task automatic add_word(logic [2:0] c, logic [3:0] s, logic [31:0] p, logic [1:0] k,
			bit drain = 0);
		stim_t t;
		t.word.command = c;
		t.word.slot = s;
		t.word.period = p;
		t.word.response = k;
		t.drain_first = drain;
		cmd_q.push_back(t);
	endtask

	function automatic logic [31:0] pick_period();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(0, 24);
		else if (r < 90)
			return $urandom();
		else
			return 32'hFFFF_FFF0 + $urandom_range(0, 15);
	endfunction

	task automatic note_mismatch(string field, logic [63:0] want, logic [63:0] got);
		if (errors < 10)
			$display("mismatch on %s: expected %h, got %h", field, want, got);
		errors++;
	endtask

	always @(posedge clk) begin : drive
		bit offer;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				answer_q.push_back(queue_answer(req));
				sent++;
			end
			if ((req_valid && req_ready) || !req_valid) begin
				offer = 0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (cmd_q.size() > 0) begin
					if (cmd_q[0].drain_first && answer_q.size() != 0) begin
						offer = 0;
					end else if (!calm && $urandom_range(0, 9) == 0) begin
						gap_left = $urandom_range(1, 19) - 1;
					end else begin
						offer = 1;
						req <= cmd_q[0].word;
						cmd_q.pop_front();
					end
				end
				req_valid <= offer;
			end
			calm <= cmd_q.size() < CALM_TAIL;
		end
	end

	always @(posedge clk) begin : receive
		rsp_word_t want;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (answer_q.size() == 0) begin
					if (errors < 10)
						$display("unexpected response word %h", rsp);
					errors++;
				end else begin
					want = answer_q.pop_front();
					if (rsp.expired_found !== want.expired_found)
						note_mismatch("expired_found", 64'(want.expired_found),
							64'(rsp.expired_found));
					if (rsp.expired_slot !== want.expired_slot)
						note_mismatch("expired_slot", 64'(want.expired_slot),
							64'(rsp.expired_slot));
					if (rsp.remaining_ms !== want.remaining_ms)
						note_mismatch("remaining_ms", 64'(want.remaining_ms),
							64'(rsp.remaining_ms));
					if (rsp.time_now !== want.time_now)
						note_mismatch("time_now", want.time_now, rsp.time_now);
					if (rsp.command_error !== want.command_error)
						note_mismatch("command_error", 64'(want.command_error),
							64'(rsp.command_error));
				end
			end
			if (long_hold) begin
				rsp_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 19) - 1;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : hold_off
		if (arst_n) begin
			if (!hold_done && sent >= HOLD_AT) begin
				hold_done = 1;
				hold_left = LONG_HOLD;
				long_hold <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left--;
				long_hold <= hold_left != 0;
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycles++;
		if (cycles > LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin : main
		bit after_service;
		int r;
		logic [2:0] c;

		// empty queue, bad respond, saturation and tie order
		add_word(CMD_QUERY, 4'd0, $urandom(), RESP_NONE);
		add_word(CMD_RESPOND, 4'd0, $urandom(), RESP_SAME);
		add_word(CMD_SERVICE, 4'd0, $urandom(), RESP_NONE);
		add_word(CMD_START, 4'd0, 32'd0, RESP_NONE);
		add_word(CMD_START, 4'd15, 32'd0, RESP_NONE);
		add_word(CMD_QUERY, 4'd0, 32'd0, RESP_NONE);
		add_word(CMD_SERVICE, 4'd3, 32'd0, RESP_NONE);
		add_word(CMD_RESPOND, 4'd0, 32'hFFFF_FFFF, RESP_SAME);
		add_word(CMD_SERVICE, 4'd0, 32'd0, RESP_NONE);
		add_word(CMD_RESPOND, 4'd0, 32'd9, RESP_NONE);
		add_word(CMD_SERVICE, 4'd0, 32'd0, RESP_NONE);
		add_word(CMD_SERVICE, 4'd0, 32'd0, RESP_NONE);
		add_word(CMD_RESPOND, 4'd0, 32'd5, RESP_ODD);
		add_word(CMD_START, 4'd7, 32'hFFFF_FFFF, RESP_NONE);
		add_word(CMD_QUERY, 4'd7, 32'd0, RESP_NONE);
		add_word(CMD_TICK, 4'd15, 32'hFFFF_FFFF, RESP_ODD);
		add_word(CMD_QUERY, 4'd7, 32'd0, RESP_NONE);
		add_word(CMD_STOP, 4'd7, 32'd0, RESP_NONE);
		add_word(CMD_QUERY, 4'd7, 32'd0, RESP_NONE);
		add_word(CMD_SPARE6, 4'($urandom()), $urandom(), 2'($urandom()));
		add_word(CMD_SPARE7, 4'($urandom()), $urandom(), 2'($urandom()));
		add_word(CMD_START, 4'd1, 32'd0, RESP_NONE);
		add_word(CMD_START, 4'd2, 32'd0, RESP_NONE);
		add_word(CMD_SERVICE, 4'd0, 32'd0, RESP_NONE);
		add_word(CMD_SERVICE, 4'd0, 32'd0, RESP_NONE);
		add_word(CMD_RESPOND, 4'd0, 32'h20, RESP_NEW);
		add_word(CMD_START, 4'd3, 32'd0, RESP_NONE);
		add_word(CMD_SERVICE, 4'd0, 32'd0, RESP_NONE);
		add_word(CMD_START, 4'd3, 32'd100, RESP_NONE);
		add_word(CMD_RESPOND, 4'd0, 32'd0, RESP_SAME);

		// random traffic, service mostly answered straight away
		after_service = 0;
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			r = $urandom_range(0, 99);
			if (after_service && $urandom_range(0, 9) < 7)
				c = CMD_RESPOND;
			else if (r < 30)
				c = CMD_TICK;
			else if (r < 50)
				c = CMD_START;
			else if (r < 55)
				c = CMD_STOP;
			else if (r < 70)
				c = CMD_QUERY;
			else if (r < 85)
				c = CMD_SERVICE;
			else if (r < 97)
				c = CMD_RESPOND;
			else
				c = $urandom_range(0, 1) ? CMD_SPARE6 : CMD_SPARE7;
			after_service = (c == CMD_SERVICE);
			add_word(c, 4'($urandom()), pick_period(), 2'($urandom()),
				i == 700 || i == 1200);
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(negedge clk);
		while (cmd_q.size() != 0 || req_valid || answer_q.size() != 0);
		repeat (SETTLE) @(negedge clk);

		if (errors == 0 && answer_q.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
